[hw/rtl/ilid_pkg.sv]
package ilid_pkg;

   localparam int CapacityDefault = 64;

   localparam logic [2:0] OP_READ = 3'd0;
   localparam logic [2:0] OP_HEAD = 3'd1;
   localparam logic [2:0] OP_TAIL = 3'd2;
   localparam logic [2:0] OP_AT   = 3'd3;
   localparam logic [2:0] OP_DEL  = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic signed [31:0] NEG_ONE = -32'sd1;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [9:0]         position;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [6:0]         list_length;
   } rsp_type;

   typedef struct packed {
      logic               insert;
      logic               remove;
      logic signed [31:0] value;
   } cell_ctl_type;

endpackage

[hw/rtl/ilid_cell.sv]
module ilid_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                       clock,
   input  ilid_pkg::cell_ctl_type     ctl,
   input  logic [CNT_W-1:0]           slot,
   input  logic signed [31:0]         left_data,
   input  logic signed [31:0]         right_data,
   output logic signed [31:0]         data,
   output logic signed [31:0]         hit_data
);
   import ilid_pkg::*;

   localparam logic [CNT_W-1:0] Idx = CNT_W'(INDEX);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.insert) begin
         if (Idx == slot) begin
            data_in = ctl.value;
         end else if (Idx > slot) begin
            data_in = left_data;
         end
      end else if (ctl.remove) begin
         if (Idx >= slot) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign hit_data = (Idx == slot) ? data_ff : 32'sd0;

endmodule

[hw/rtl/indexed_list_insert_delete.sv]
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// The request channel (req_valid, req_stall, req_data) carries one operation
// per beat: read at an index, insert at head, insert at tail, insert before an
// index, or delete at an index. Every request beat yields exactly one response
// beat on the rsp channel with the value read (or -1), a status code and the
// list length after the operation.
// All cells shift toward or away from the target slot together, and a read
// selects the matching cell. The response is registered in the output
// register, or in a second result register while the output waits; one
// request beat can be taken every cycle while req_stall is low.
// A second result register stands behind the output register, so a request is
// still taken while one response waits; req_stall rises only when both are
// full, which happens when rsp_stall is held.
// Synchronous reset empties the list and drops any pending responses. Cell
// contents are not cleared; only slots below the length are ever read.
module indexed_list_insert_delete #(
   parameter int CAPACITY = ilid_pkg::CapacityDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ilid_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ilid_pkg::rsp_type rsp_data
);
   import ilid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;
   rsp_type            skid_data_ff;
   rsp_type            skid_data_in;

   logic               accept;
   logic               out_free;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic               full;
   logic [CNT_W-1:0]   slot;
   cell_ctl_type       ctl;
   rsp_type            result;
   logic signed [31:0] read_hit;

   logic signed [31:0] cell_data [CAPACITY];
   logic signed [31:0] cell_hit  [CAPACITY];

   assign accept   = req_valid && !skid_valid_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pos_ext  = CMP_W'(req_data.position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign full     = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      read_hit = 32'sd0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_hit = read_hit | cell_hit[i];
      end
   end

   always_comb begin
      ctl.insert = 1'b0;
      ctl.remove = 1'b0;
      ctl.value  = req_data.item_value;
      slot       = CNT_W'(pos_ext);
      result.read_value = NEG_ONE;
      result.status     = ST_DONE;
      count_in   = count_ff;
      case (req_data.opcode)
         OP_READ: begin
            if (pos_ext < cnt_ext) begin
               result.read_value = read_hit;
            end else begin
               result.status = ST_RANGE;
            end
         end
         OP_HEAD: begin
            slot = '0;
            if (full) begin
               result.status = ST_FULL;
            end else begin
               ctl.insert = 1'b1;
            end
         end
         OP_TAIL: begin
            slot = count_ff;
            if (full) begin
               result.status = ST_FULL;
            end else begin
               ctl.insert = 1'b1;
            end
         end
         OP_AT: begin
            if (pos_ext > cnt_ext) begin
               result.status = ST_RANGE;
            end else if (full) begin
               result.status = ST_FULL;
            end else begin
               ctl.insert = 1'b1;
            end
         end
         OP_DEL: begin
            if (pos_ext < cnt_ext) begin
               ctl.remove = 1'b1;
            end else begin
               result.status = ST_RANGE;
            end
         end
         default: begin
            result.status = ST_RANGE;
         end
      endcase
      if (!accept) begin
         ctl.insert = 1'b0;
         ctl.remove = 1'b0;
      end
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
      result.list_length = 7'(count_in);
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : gen_cells
      logic signed [31:0] left_data;
      logic signed [31:0] right_data;
      if (g == 0) begin : gen_first
         assign left_data = ctl.value;
      end else begin : gen_mid_left
         assign left_data = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : gen_last
         assign right_data = cell_data[g];
      end else begin : gen_mid_right
         assign right_data = cell_data[g+1];
      end
      ilid_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .slot       (slot),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[g]),
         .hit_data   (cell_hit[g])
      );
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
